// ===== rtl/rfl_pkg.sv =====
// ----------------------------------------------------------------------------
// rfl_pkg
// Shared widths and codes for the ring free-list allocator.
// ----------------------------------------------------------------------------
package rfl_pkg;

	localparam int ADDR_W = 48;
	localparam int SIZE_W = 21;
	localparam int OP_W   = 2;
	localparam int IDX_W  = 1;

	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESTORE = 2'd2
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_BASE_ADDRESS = 1'b0,
		CFG_BLOCK_SIZE   = 1'b1
	} cfg_idx_t;

endpackage

// ===== rtl/rfl_ram.sv =====
// ----------------------------------------------------------------------------
// rfl_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module rfl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ring_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// ring_free_list_allocator
// Fixed-block allocator keeping a ring of free block addresses.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input stage, then the result register.
// Throughput: one item per cycle while no result beat is stalled by rsp_stall,
// set by the single ring RAM port pair.
// Reset: head at POOL_DEPTH-1, tail at 0, base 0, block size 64. A fill count
// tracks which ring entries were written since reset or restore; the others
// read as computed pool addresses, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_free_list_allocator
	import rfl_pkg::*;
#(
	parameter int POOL_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [ADDR_W-1:0] block_addr,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [ADDR_W-1:0] granted_addr,
	output logic              alloc_ok
);

	localparam int PTR_W  = $clog2(POOL_DEPTH);
	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int PROD_W = PTR_W + SIZE_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_DEPTH);

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  fill_q;

	logic              valid_s1;
	logic              ok_s1;
	logic              hit_s1;
	logic [PROD_W-1:0] prod_s1;

	logic              rsp_valid_q;
	logic [ADDR_W-1:0] granted_q;
	logic              ok_q;

	logic              accept;
	logic              adv_s1;
	logic              do_alloc;
	logic              do_free;
	logic [PTR_W-1:0]  head_nxt;
	logic [PTR_W-1:0]  tail_nxt;
	logic [PTR_W-1:0]  offset;
	logic [ADDR_W-1:0] ram_rdata;
	logic [ADDR_W-1:0] addr_s1;

	assign cfg_ready = 1'b1;

	assign adv_s1    = valid_s1 && !(rsp_valid_q && rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign accept    = req_valid && !req_stall;

	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign offset   = PTR_LAST - tail_q;

	assign do_alloc = accept && (op == OP_ALLOC) && (tail_q != head_q);
	assign do_free  = accept && (op == OP_FREE);

	rfl_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(POOL_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (do_free),
		.waddr(head_q),
		.wdata(block_addr),
		.re   (do_alloc),
		.raddr(tail_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= BLOCK_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE_ADDRESS: base_q <= cfg_data;
				CFG_BLOCK_SIZE:   size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= PTR_LAST;
			tail_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			case (op)
				OP_ALLOC: begin
					if (tail_q != head_q) begin
						tail_q <= tail_nxt;
					end
				end
				OP_FREE: begin
					head_q <= head_nxt;
					if (fill_q != CNT_FULL) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				OP_RESTORE: begin
					head_q <= PTR_LAST;
					tail_q <= '0;
					fill_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= do_alloc;
			hit_s1  <= CNT_W'(tail_nxt) < fill_q;
			prod_s1 <= PROD_W'(offset) * PROD_W'(size_q);
		end
	end

	assign addr_s1 = hit_s1 ? ram_rdata : base_q + ADDR_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			granted_q <= ok_s1 ? addr_s1 : '0;
			ok_q      <= ok_s1;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign granted_addr = granted_q;
	assign alloc_ok     = ok_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ring free-list allocator against its own model of the free ring.
// A short table of directed beats covers reset contents, register extremes,
// the empty pool, overfill, restore and the unused op code, and then random
// phases with fresh register settings mix alloc and free traffic. Every
// result beat is compared field by field with the oldest predicted grant.
// ----------------------------------------------------------------------------
module testbench;
	import rfl_pkg::*;

	localparam int POOL_DEPTH = 256;
	localparam int PTR_W      = 8;
	localparam int SETTLE     = 8;
	localparam int LIMIT      = 200000;
	localparam int PHASES     = 5;
	localparam int PHASE_LEN  = 130;

	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] MAX_ADDR  = '1;
	localparam logic [ADDR_W-1:0] MAX_SIZE  = 48'd1048576;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              ok;
	} grant_t;

	localparam grant_t NO_GRANT = '{48'd0, 1'b0};

	typedef struct {
		bit                is_cfg;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		bit                typed;
		grant_t            want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [ADDR_W-1:0] cfg_data;
	logic              req_valid;
	logic              req_stall;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] block_addr;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [ADDR_W-1:0] granted_addr;
	logic              alloc_ok;

	logic [ADDR_W-1:0] ring [POOL_DEPTH];
	bit                ring_valid [POOL_DEPTH];
	logic [PTR_W-1:0]  head;
	logic [PTR_W-1:0]  tail;
	logic [ADDR_W-1:0] cur_base;
	logic [SIZE_W-1:0] cur_size;

	grant_t pending_grants [$];
	row_t   rows [$];
	bit     failed;
	bit     calm;
	int     cycles = 0;

	ring_free_list_allocator #(
		.POOL_DEPTH(POOL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.block_addr(block_addr),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.granted_addr(granted_addr),
		.alloc_ok(alloc_ok)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		case ($urandom_range(7))
			0: return '0;
			1: return MAX_ADDR;
			default: return ADDR_W'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic grant_for(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
			output grant_t g);
		logic [ADDR_W-1:0] slot;
		g = NO_GRANT;
		case (o)
			OP_ALLOC: begin
				if (tail != head) begin
					slot = ADDR_W'(POOL_DEPTH - 1) - ADDR_W'(tail);
					g.addr = ring_valid[tail] ? ring[tail] : cur_base + slot * ADDR_W'(cur_size);
					g.ok = 1'b1;
					tail = tail + 1'b1;
				end
			end
			OP_FREE: begin
				ring[head] = a;
				ring_valid[head] = 1'b1;
				head = head + 1'b1;
			end
			OP_RESTORE: begin
				ring_valid = '{default: 1'b0};
				head = PTR_W'(POOL_DEPTH - 1);
				tail = '0;
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
			input bit typed, input grant_t typed_grant);
		grant_t g;
		if (!calm && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 10);
		end
		req_valid  <= 1'b1;
		op         <= o;
		block_addr <= a;
		// hold the beat until accepted
		@(posedge clk);
		while (req_stall) @(posedge clk);
		grant_for(o, a, g);
		pending_grants.push_back(typed ? typed_grant : g);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] s);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_data  <= b;
		do @(posedge clk); while (!cfg_ready);
		cur_base = b;
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data  <= s;
		do @(posedge clk); while (!cfg_ready);
		cur_size = s[SIZE_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : rsp_check
		grant_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual granted_addr %h alloc_ok %b",
					$time, granted_addr, alloc_ok);
				failed = 1'b1;
			end else begin
				want = pending_grants.pop_front();
				if (granted_addr !== want.addr) begin
					$display("%0t granted_addr: expected %h, actual %h",
						$time, want.addr, granted_addr);
					failed = 1'b1;
				end
				if (alloc_ok !== want.ok) begin
					$display("%0t alloc_ok: expected %b, actual %b", $time, want.ok, alloc_ok);
					failed = 1'b1;
				end
			end
		end
		rsp_stall <= !calm && ($urandom_range(99) < 10);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] size_val;
		int alloc_pct;
		int r;
		logic [OP_W-1:0] o;
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_BASE_ADDRESS;
		cfg_data   = '0;
		req_valid  = 1'b0;
		op         = OP_ALLOC;
		block_addr = '0;
		failed     = 1'b0;
		calm       = 1'b0;
		ring_valid = '{default: 1'b0};
		head       = PTR_W'(POOL_DEPTH - 1);
		tail       = '0;
		cur_base   = '0;
		cur_size   = BLOCK_SIZE_RST;

		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, grant_t'{48'h3FC0, 1'b1}});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, MAX_ADDR, 1, grant_t'{48'h3F80, 1'b1}});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, MAX_ADDR, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_UNUSED, MAX_ADDR, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_RESTORE, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, grant_t'{48'h3FC0, 1'b1}});
		rows.push_back(row_t'{1, MAX_ADDR, MAX_SIZE, OP_ALLOC, 48'd0, 0, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_RESTORE, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 0, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 0, NO_GRANT});
		rows.push_back(row_t'{1, 48'h1234_5678_9ABC, 48'd0, OP_ALLOC, 48'd0, 0, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1,
			grant_t'{48'h1234_5678_9ABC, 1'b1}});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_RESTORE, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'hA5A5_A5A5_A5A5, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'h5A5A_5A5A_5A5A, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1,
			grant_t'{48'h5A5A_5A5A_5A5A, 1'b1}});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{1, 48'd0, 48'd1, OP_ALLOC, 48'd0, 0, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_RESTORE, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, grant_t'{48'd255, 1'b1}});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_UNUSED, 48'd0, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'd1, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'd2, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_FREE, 48'd3, 1, NO_GRANT});
		rows.push_back(row_t'{0, 48'd0, 48'd0, OP_ALLOC, 48'd0, 1, grant_t'{48'd3, 1'b1}});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				write_regs(rows[i].base, rows[i].size);
			end else begin
				send_item(rows[i].op, rows[i].addr, rows[i].typed, rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm = (ph == 2);
			case ($urandom_range(7))
				0: size_val = '0;
				1: size_val = 48'd1;
				2: size_val = MAX_SIZE;
				3: size_val = ADDR_W'({$urandom(), $urandom()});
				default: size_val = ADDR_W'($urandom() & 32'h1F_FFFF);
			endcase
			write_regs(rand_addr(), size_val);
			case ($urandom_range(3))
				0: alloc_pct = 20;
				3: alloc_pct = 80;
				default: alloc_pct = 50;
			endcase
			repeat (PHASE_LEN) begin
				r = $urandom_range(999);
				if (r < 8)
					o = OP_UNUSED;
				else if (r < 16)
					o = OP_RESTORE;
				else if ($urandom_range(99) < alloc_pct)
					o = OP_ALLOC;
				else
					o = OP_FREE;
				send_item(o, rand_addr(), 1'b0, NO_GRANT);
			end
		end

		drain();
		if (!failed && pending_grants.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
